>>> sv/ffha_pkg.sv
// Shared constants and codes of the first-fit heap allocator.
`timescale 1ns / 1ps

package ffha_pkg;

  // Default heap geometry (ALIGN_BYTES must be a power of two)
  localparam int unsigned HeapBytesDef     = 4096;
  localparam int unsigned AlignBytesDef    = 8;
  localparam int unsigned HeaderBytesDef   = 8;
  localparam int unsigned MinSplitBytesDef = 16;

  // Field widths of the words on the channels
  localparam int unsigned ReqSizeW = 16;
  localparam int unsigned AddrW    = 12;
  localparam int unsigned BytesW   = 13;
  localparam int unsigned StatusW  = 2;
  // Width of a request size plus header, rounded up
  localparam int unsigned WantW    = 17;

  // Request codes
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] ST_DONE   = 2'd0;
  localparam logic [StatusW-1:0] ST_FAIL   = 2'd1;
  localparam logic [StatusW-1:0] ST_REJECT = 2'd2;

endpackage

>>> sv/ffha_req_if.sv
// Request channel: one allocate or free word per handshake.
`timescale 1ns / 1ps

interface ffha_req_if import ffha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [ReqSizeW-1:0] req_size;
  logic [AddrW-1:0]    block_addr;

  modport source (output valid, output req_type, output req_size, output block_addr,
                  input ready);
  modport sink   (input valid, input req_type, input req_size, input block_addr,
                  output ready);
endinterface

>>> sv/ffha_rsp_if.sv
// Result channel: one status word per request.
`timescale 1ns / 1ps

interface ffha_rsp_if import ffha_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [AddrW-1:0]   payload_addr;
  logic [BytesW-1:0]  bytes_free;
  logic [BytesW-1:0]  bytes_free_min;

  modport source (output valid, output status, output payload_addr, output bytes_free,
                  output bytes_free_min, input ready);
  modport sink   (input valid, input status, input payload_addr, input bytes_free,
                  input bytes_free_min, output ready);
endinterface

>>> sv/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator with a header memory and list walker.
`timescale 1ns / 1ps

// Usage:
//   req_i carries allocate (req_type 0, req_size payload bytes) and free
//   (req_type 1, block_addr payload offset) words; rsp_o returns one word per
//   request: status, payload offset, free byte total and its low-water mark.
//   Block headers live in one memory of HEAP_BYTES/ALIGN_BYTES entries (size,
//   allocated flag, next-free link), whose reads are registered. One request
//   is worked on at a time.
//   Reset: after rst_ni the header memory is swept, one entry per cycle, over
//   all HEAP_BYTES/ALIGN_BYTES entries (512 by default); req_i.ready stays low
//   meanwhile. The heap then holds one free block and the end sentinel.
//   Stall: the result sits in an output register; the next request is taken
//   while it waits, and a further result holds until rsp_o.ready is seen.
//   ALIGN_BYTES must be a power of two.
module first_fit_heap_allocator_top import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES      = HeapBytesDef,
  parameter int unsigned ALIGN_BYTES     = AlignBytesDef,
  parameter int unsigned HEADER_BYTES    = HeaderBytesDef,
  parameter int unsigned MIN_SPLIT_BYTES = MinSplitBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ffha_req_if.sink   req_i,
  ffha_rsp_if.source rsp_o
);

  localparam int unsigned Units    = HEAP_BYTES / ALIGN_BYTES;
  localparam int unsigned EndUnit  = (HEAP_BYTES - HEADER_BYTES) / ALIGN_BYTES;
  localparam int unsigned InitFree = EndUnit * ALIGN_BYTES;
  localparam int unsigned Alb      = $clog2(ALIGN_BYTES);
  localparam int unsigned Iw       = $clog2(Units);
  localparam int unsigned Lw       = $clog2(Units + 1);
  localparam int unsigned Nw       = $clog2(Units + 2);
  localparam int unsigned Bw       = $clog2(HEAP_BYTES + 1);
  localparam int unsigned Xw0      = Nw + Alb + 2;
  localparam int unsigned Xw       = (Xw0 > WantW) ? Xw0 : WantW;
  localparam int unsigned Stw      = $clog2(Units + 2);

  localparam logic [Nw-1:0] NodeNone  = Nw'(Units);
  localparam logic [Nw-1:0] NodeStart = Nw'(Units + 1);
  localparam logic [Nw-1:0] NodeEnd   = Nw'(EndUnit);

  typedef struct packed {
    logic          alloc;
    logic [Bw-1:0] size;
    logic [Lw-1:0] link;
  } entry_t;

  // Sequencer states
  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_A_LOOK = 4'd2;
  localparam logic [3:0] S_A_CHK  = 4'd3;
  localparam logic [3:0] S_A_WPRV = 4'd4;
  localparam logic [3:0] S_A_WCUR = 4'd5;
  localparam logic [3:0] S_F_RD   = 4'd6;
  localparam logic [3:0] S_F_CHK  = 4'd7;
  localparam logic [3:0] S_I_WINS = 4'd8;
  localparam logic [3:0] S_I_STEP = 4'd9;
  localparam logic [3:0] S_I_RD   = 4'd10;
  localparam logic [3:0] S_I_MRG  = 4'd11;
  localparam logic [3:0] S_I_NXT  = 4'd12;
  localparam logic [3:0] S_I_WFIN = 4'd13;
  localparam logic [3:0] S_I_WIT  = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  logic [3:0]         state_q;
  logic [Iw-1:0]      clr_idx_q;
  logic [Nw-1:0]      head_q;
  logic [Bw-1:0]      free_total_q;
  logic [Bw-1:0]      free_low_q;
  logic [WantW-1:0]   want_q;
  logic [Nw-1:0]      cur_q, prev_q, cur_link_q;
  logic [Bw-1:0]      prev_size_q, fs_q;
  logic               prev_alloc_q;
  logic               split_q;
  logic [Nw-1:0]      ins_q, it_q, it_link_q, fin_link_q;
  logic [Bw-1:0]      ins_size_q, it_size_q;
  logic               it_alloc_q;
  logic [Stw-1:0]     steps_q;
  logic [StatusW-1:0] res_status_q;
  logic [AddrW-1:0]   res_payload_q;

  logic               out_valid_q;
  logic [StatusW-1:0] out_status_q;
  logic [AddrW-1:0]   out_payload_q;
  logic [BytesW-1:0]  out_free_q, out_free_min_q;

  // Header memory
  entry_t        mem [Units];
  entry_t        rd_q;
  logic          mem_we, mem_re;
  logic [Iw-1:0] mem_wa, mem_ra;
  entry_t        mem_wd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // Read link widened to node width
  logic [Nw-1:0] rd_link;
  assign rd_link = Nw'(rd_q.link);

  // Request decode at the input
  logic [WantW-1:0] want_c;
  logic [AddrW-1:0] hb_c;
  logic [Xw-1:0]    unit_c;
  logic             free_ok_c;

  assign want_c = (WantW'(req_i.req_size) + WantW'(HEADER_BYTES) + WantW'(ALIGN_BYTES - 1))
                  & ~WantW'(ALIGN_BYTES - 1);
  assign hb_c   = req_i.block_addr - AddrW'(HEADER_BYTES);
  assign unit_c = Xw'(hb_c) >> Alb;
  assign free_ok_c = (Xw'(req_i.block_addr) >= Xw'(HEADER_BYTES))
                     && ((Xw'(hb_c) & Xw'(ALIGN_BYTES - 1)) == '0)
                     && (unit_c < Xw'(EndUnit));

  // Walk and merge arithmetic
  logic          walk_more_c, found_c, ins_more_c, adj_prev_c, adj_next_c;
  logic [Bw-1:0] rem_c, fs_c;
  logic [Xw-1:0] nb_c;
  logic          split_c;

  assign walk_more_c = (Xw'(rd_q.size) < Xw'(want_q)) && (rd_link != NodeNone)
                       && (Xw'(steps_q) <= Xw'(Units));
  assign found_c     = (cur_q != NodeEnd) && (Xw'(rd_q.size) >= Xw'(want_q));
  assign rem_c       = Bw'(Xw'(fs_q) - Xw'(want_q));
  assign nb_c        = Xw'(cur_q) + (Xw'(want_q) >> Alb);
  assign split_c     = (Xw'(rem_c) > Xw'(MIN_SPLIT_BYTES)) && (nb_c < Xw'(Units));
  assign fs_c        = split_c ? Bw'(want_q) : fs_q;
  assign ins_more_c  = (it_link_q < ins_q) && (Xw'(steps_q) <= Xw'(Units));
  assign adj_prev_c  = (it_q < NodeNone)
                       && ((Xw'(it_q) << Alb) + Xw'(it_size_q) == (Xw'(ins_q) << Alb));
  assign adj_next_c  = ((Xw'(ins_q) << Alb) + Xw'(ins_size_q) == (Xw'(it_link_q) << Alb));

  // Memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = '0;
    case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx_q;
        if (clr_idx_q == '0) begin
          mem_wd.size = Bw'(InitFree);
          mem_wd.link = Lw'(EndUnit);
        end else if (clr_idx_q == Iw'(EndUnit)) begin
          mem_wd.link = Lw'(Units);
        end
      end
      S_A_LOOK: begin
        mem_re = (cur_q < NodeNone);
        mem_ra = cur_q[Iw-1:0];
      end
      S_A_WPRV: begin
        mem_we = (prev_q != NodeStart);
        mem_wa = prev_q[Iw-1:0];
        mem_wd = '{alloc: prev_alloc_q, size: prev_size_q, link: Lw'(cur_link_q)};
      end
      S_A_WCUR: begin
        mem_we = 1'b1;
        mem_wa = cur_q[Iw-1:0];
        mem_wd = '{alloc: 1'b1, size: fs_q, link: Lw'(Units)};
      end
      S_F_RD: begin
        mem_re = 1'b1;
        mem_ra = ins_q[Iw-1:0];
      end
      S_I_WINS: begin
        mem_we = 1'b1;
        mem_wa = ins_q[Iw-1:0];
        mem_wd = '{alloc: 1'b0, size: ins_size_q, link: Lw'(Units)};
      end
      S_I_STEP: begin
        mem_re = ins_more_c;
        mem_ra = it_link_q[Iw-1:0];
      end
      S_I_MRG: begin
        mem_re = (it_link_q < NodeNone);
        mem_ra = it_link_q[Iw-1:0];
      end
      S_I_WFIN: begin
        mem_we = 1'b1;
        mem_wa = ins_q[Iw-1:0];
        mem_wd = '{alloc: 1'b0, size: ins_size_q, link: Lw'(fin_link_q)};
      end
      S_I_WIT: begin
        mem_we = 1'b1;
        mem_wa = it_q[Iw-1:0];
        mem_wd = '{alloc: it_alloc_q, size: it_size_q, link: Lw'(ins_q)};
      end
      default: begin
      end
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);

  // Sequencer: decode, walk, update headers, hand off result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      clr_idx_q      <= '0;
      head_q         <= '0;
      free_total_q   <= Bw'(InitFree);
      free_low_q     <= Bw'(InitFree);
      want_q         <= '0;
      cur_q          <= '0;
      prev_q         <= '0;
      cur_link_q     <= '0;
      prev_size_q    <= '0;
      prev_alloc_q   <= 1'b0;
      fs_q           <= '0;
      split_q        <= 1'b0;
      ins_q          <= '0;
      ins_size_q     <= '0;
      it_q           <= '0;
      it_link_q      <= '0;
      it_size_q      <= '0;
      it_alloc_q     <= 1'b0;
      fin_link_q     <= '0;
      steps_q        <= '0;
      res_status_q   <= ST_DONE;
      res_payload_q  <= '0;
      out_valid_q    <= 1'b0;
      out_status_q   <= ST_DONE;
      out_payload_q  <= '0;
      out_free_q     <= '0;
      out_free_min_q <= '0;
    end else begin
      // Drop the result word once taken, unless a new one replaces it
      if (out_valid_q && rsp_o.ready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_idx_q <= clr_idx_q + Iw'(1);
          if (clr_idx_q == Iw'(Units - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_i.valid) begin
            res_payload_q <= '0;
            steps_q       <= '0;
            if (req_i.req_type == REQ_ALLOC) begin
              want_q <= want_c;
              cur_q  <= head_q;
              prev_q <= NodeStart;
              if ((req_i.req_size == '0) || (Xw'(want_c) > Xw'(free_total_q))) begin
                res_status_q <= ST_FAIL;
                state_q      <= S_DONE;
              end else begin
                state_q <= S_A_LOOK;
              end
            end else if (free_ok_c) begin
              ins_q   <= Nw'(unit_c);
              state_q <= S_F_RD;
            end else begin
              res_status_q <= ST_REJECT;
              state_q      <= S_DONE;
            end
          end
        end
        S_A_LOOK: begin
          if (cur_q < NodeNone) begin
            state_q <= S_A_CHK;
          end else begin
            res_status_q <= ST_FAIL;
            state_q      <= S_DONE;
          end
        end
        S_A_CHK: begin
          if (walk_more_c) begin
            prev_q       <= cur_q;
            prev_size_q  <= rd_q.size;
            prev_alloc_q <= rd_q.alloc;
            cur_q        <= rd_link;
            steps_q      <= steps_q + Stw'(1);
            state_q      <= S_A_LOOK;
          end else if (found_c) begin
            fs_q       <= rd_q.size;
            cur_link_q <= rd_link;
            state_q    <= S_A_WPRV;
          end else begin
            res_status_q <= ST_FAIL;
            state_q      <= S_DONE;
          end
        end
        S_A_WPRV: begin
          // Unlink the block, then decide on a split and charge its size
          if (prev_q == NodeStart) begin
            head_q <= cur_link_q;
          end
          split_q      <= split_c;
          ins_q        <= Nw'(nb_c);
          ins_size_q   <= rem_c;
          fs_q         <= fs_c;
          free_total_q <= free_total_q - fs_c;
          if ((free_total_q - fs_c) < free_low_q) begin
            free_low_q <= free_total_q - fs_c;
          end
          state_q <= S_A_WCUR;
        end
        S_A_WCUR: begin
          res_status_q  <= ST_DONE;
          res_payload_q <= AddrW'((Xw'(cur_q) << Alb) + Xw'(HEADER_BYTES));
          state_q       <= split_q ? S_I_WINS : S_DONE;
        end
        S_F_RD: begin
          state_q <= S_F_CHK;
        end
        S_F_CHK: begin
          if (rd_q.alloc && (rd_link == NodeNone)) begin
            ins_size_q   <= rd_q.size;
            free_total_q <= free_total_q + rd_q.size;
            res_status_q <= ST_DONE;
            state_q      <= S_I_WINS;
          end else begin
            res_status_q <= ST_REJECT;
            state_q      <= S_DONE;
          end
        end
        S_I_WINS: begin
          it_q       <= NodeStart;
          it_link_q  <= head_q;
          it_size_q  <= '0;
          it_alloc_q <= 1'b0;
          steps_q    <= '0;
          state_q    <= S_I_STEP;
        end
        S_I_STEP: begin
          state_q <= ins_more_c ? S_I_RD : S_I_MRG;
        end
        S_I_RD: begin
          it_q       <= it_link_q;
          it_size_q  <= rd_q.size;
          it_alloc_q <= rd_q.alloc;
          it_link_q  <= rd_link;
          steps_q    <= steps_q + Stw'(1);
          state_q    <= S_I_STEP;
        end
        S_I_MRG: begin
          // Merge into the lower neighbor when they touch
          if (adj_prev_c) begin
            ins_q      <= it_q;
            ins_size_q <= it_size_q + ins_size_q;
          end
          fin_link_q <= it_link_q;
          state_q    <= (it_link_q < NodeNone) ? S_I_NXT : S_I_WFIN;
        end
        S_I_NXT: begin
          // Absorb the upper neighbor, except the end sentinel
          if (adj_next_c) begin
            if (it_link_q != NodeEnd) begin
              ins_size_q <= ins_size_q + rd_q.size;
              fin_link_q <= rd_link;
            end else begin
              fin_link_q <= NodeEnd;
            end
          end
          state_q <= S_I_WFIN;
        end
        S_I_WFIN: begin
          if (ins_q != it_q) begin
            if (it_q == NodeStart) begin
              head_q  <= ins_q;
              state_q <= S_DONE;
            end else begin
              state_q <= S_I_WIT;
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        S_I_WIT: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          // Hand off once the output register is free
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q    <= 1'b1;
            out_status_q   <= res_status_q;
            out_payload_q  <= res_payload_q;
            out_free_q     <= BytesW'(free_total_q);
            out_free_min_q <= BytesW'(free_low_q);
            state_q        <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.payload_addr   = out_payload_q;
  assign rsp_o.bytes_free     = out_free_q;
  assign rsp_o.bytes_free_min = out_free_min_q;

`ifndef SYNTHESIS
  a_low_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_low_q <= free_total_q)
    else $error("low-water mark above free total");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_total_q <= Bw'(InitFree))
    else $error("free total above heap capacity");

  a_no_accept_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> !req_i.ready)
    else $error("request taken during clearing pass");

  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status != ST_DONE |-> rsp_o.payload_addr == '0)
    else $error("payload offset on a failed request");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.status == ST_DONE || rsp_o.status == ST_FAIL
                     || rsp_o.status == ST_REJECT))
    else $error("undefined status code");
`endif

endmodule
